@@ design/char_literal_decoder_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the character literal decoder
// Short forms for clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef CHAR_LITERAL_DECODER_CORE_ASSERT_SVH
`define CHAR_LITERAL_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("char literal decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("char literal decoder check failed");

`endif

@@ design/cld_pkg.sv @@
// ---------------------------------------------------------------------------
// Character literal decoder package
// Widths, character codes, status codes and the result record.
// ---------------------------------------------------------------------------
package cld_pkg;

  localparam int CH_W    = 8;
  localparam int VALUE_W = 63;
  localparam int PACK_W  = 64;

  localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CH_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_QUOTE  = 8'h27;
  localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CH_W-1:0] CH_X      = 8'h78;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_QUOTE  = 2'd1,
    ST_UNTERM = 2'd2,
    ST_UNEXP  = 2'd3
  } cld_status_e_t;

  typedef struct packed {
    logic                valid;
    logic [VALUE_W-1:0]  value;
    cld_status_e_t       status;
    logic [CH_W-1:0]     bad_char;
  } cld_result_t;

endpackage

@@ design/cld_if.sv @@
// ---------------------------------------------------------------------------
// Character literal decoder channels
// Valid/ready interfaces for the character input and the result output.
// ---------------------------------------------------------------------------
interface cld_in_if;
  import cld_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface cld_out_if;
  import cld_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [1:0]         status;
  logic [CH_W-1:0]    bad_char;

  modport source (output valid, output value, output status, output bad_char, input ready);
  modport sink   (input valid, input value, input status, input bad_char, output ready);
endinterface

@@ design/cld_in_reg.sv @@
// ---------------------------------------------------------------------------
// Character input register
// Holds one accepted character until the decode stage takes it.
// ---------------------------------------------------------------------------
module cld_in_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [cld_pkg::CH_W-1:0] in_ch,
  input  logic                  step_adv,
  output logic                  hold_valid,
  output logic [cld_pkg::CH_W-1:0] hold_ch
);
  import cld_pkg::*;

  logic            valid_r;
  logic            valid_nxt;
  logic [CH_W-1:0] ch_r;

  assign in_ready   = !valid_r || step_adv;
  assign hold_valid = valid_r;
  assign hold_ch    = ch_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ch_r <= in_ch;
    end
  end
endmodule

@@ design/cld_step.sv @@
// ---------------------------------------------------------------------------
// Character literal decode step
// Literal state machine, packing register and escape accumulator.
// ---------------------------------------------------------------------------
module cld_step (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     ch_valid,
  input  logic [cld_pkg::CH_W-1:0] ch,
  input  logic                     out_free,
  output logic                     step_adv,
  output cld_pkg::cld_result_t     res
);
  import cld_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_FIRST = 6'b000010,
    PH_NEXT  = 6'b000100,
    PH_ESC   = 6'b001000,
    PH_HEX   = 6'b010000,
    PH_OCT   = 6'b100000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [PACK_W-1:0] pack_r, pack_nxt;
  logic [7:0]        esc_r, esc_nxt;
  logic              seen_r, seen_nxt;

  logic              emit;
  cld_status_e_t     emit_status;
  logic [VALUE_W-1:0] emit_value;
  logic [CH_W-1:0]   emit_bad;
  logic              do_after;
  logic              do_start;
  logic [PACK_W-1:0] unit_pack;
  logic              hex_ok;
  logic [3:0]        hex_val;
  logic              oct_ok;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    case (ch) inside
      [8'h30:8'h39]: hex_val = ch[3:0];
      [8'h41:8'h46], [8'h61:8'h66]: hex_val = ch[3:0] + 4'd9;
      default: hex_ok = 1'b0;
    endcase
  end

  assign oct_ok = (ch inside {[8'h30:8'h37]});

  always_comb begin
    phase_nxt   = phase_r;
    pack_nxt    = pack_r;
    esc_nxt     = esc_r;
    seen_nxt    = seen_r;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_value  = '0;
    emit_bad    = '0;
    do_after    = 1'b0;
    do_start    = 1'b0;
    unit_pack   = pack_r;

    case (phase_r)
      PH_FIRST: begin
        if (ch == CH_NUL) begin
          emit        = 1'b1;
          emit_status = ST_UNTERM;
        end else begin
          do_start = 1'b1;
        end
      end
      PH_NEXT: begin
        do_after = 1'b1;
      end
      PH_ESC: begin
        case (ch) inside
          8'h61: begin pack_nxt = {pack_r[PACK_W-9:0], 8'h07}; phase_nxt = PH_NEXT; end
          8'h62: begin pack_nxt = {pack_r[PACK_W-9:0], 8'h08}; phase_nxt = PH_NEXT; end
          8'h66: begin pack_nxt = {pack_r[PACK_W-9:0], 8'h0C}; phase_nxt = PH_NEXT; end
          8'h6E: begin pack_nxt = {pack_r[PACK_W-9:0], 8'h0A}; phase_nxt = PH_NEXT; end
          8'h72: begin pack_nxt = {pack_r[PACK_W-9:0], 8'h0D}; phase_nxt = PH_NEXT; end
          8'h74: begin pack_nxt = {pack_r[PACK_W-9:0], 8'h09}; phase_nxt = PH_NEXT; end
          8'h76: begin pack_nxt = {pack_r[PACK_W-9:0], 8'h0B}; phase_nxt = PH_NEXT; end
          CH_QUOTE, 8'h22, CH_BSLASH: begin
            pack_nxt  = {pack_r[PACK_W-9:0], ch};
            phase_nxt = PH_NEXT;
          end
          CH_X: begin
            phase_nxt = PH_HEX;
            esc_nxt   = '0;
            seen_nxt  = 1'b0;
          end
          [8'h30:8'h37]: begin
            phase_nxt = PH_OCT;
            esc_nxt   = {5'd0, ch[2:0]};
            seen_nxt  = 1'b1;
          end
          default: begin
            emit        = 1'b1;
            emit_status = ST_UNTERM;
          end
        endcase
      end
      PH_HEX: begin
        if (hex_ok) begin
          esc_nxt  = {esc_r[3:0], hex_val};
          seen_nxt = 1'b1;
        end else if (!seen_r) begin
          emit = 1'b1;
          if (ch == CH_QUOTE) begin
            emit_status = ST_UNEXP;
            emit_bad    = ch;
          end else begin
            emit_status = ST_UNTERM;
          end
        end else begin
          unit_pack = {pack_r[PACK_W-9:0], esc_r};
          do_after  = 1'b1;
        end
      end
      PH_OCT: begin
        if (oct_ok) begin
          esc_nxt = {esc_r[4:0], ch[2:0]};
        end else begin
          unit_pack = {pack_r[PACK_W-9:0], esc_r};
          do_after  = 1'b1;
        end
      end
      default: begin
        if (ch == CH_SPACE || (ch inside {[8'h09:8'h0D]})) begin
          phase_nxt = PH_IDLE;
        end else if (ch == CH_QUOTE) begin
          phase_nxt = PH_FIRST;
          pack_nxt  = '0;
          esc_nxt   = '0;
          seen_nxt  = 1'b0;
        end else begin
          emit        = 1'b1;
          emit_status = ST_QUOTE;
          emit_bad    = ch;
        end
      end
    endcase

    if (do_after) begin
      pack_nxt = unit_pack;
      if (ch == CH_QUOTE) begin
        emit        = 1'b1;
        emit_status = ST_OK;
        emit_value  = unit_pack[VALUE_W-1:0];
      end else if (ch == CH_NUL || ch == CH_NL || (|unit_pack[PACK_W-1:55])) begin
        emit        = 1'b1;
        emit_status = ST_UNTERM;
      end else begin
        do_start = 1'b1;
      end
    end

    if (do_start) begin
      if (ch == CH_BSLASH) begin
        phase_nxt = PH_ESC;
      end else begin
        pack_nxt  = {unit_pack[PACK_W-9:0], ch};
        phase_nxt = PH_NEXT;
      end
    end

    if (emit) begin
      phase_nxt = PH_IDLE;
    end
  end

  assign step_adv     = ch_valid && (!emit || out_free);
  assign res.valid    = step_adv && emit;
  assign res.value    = emit_value;
  assign res.status   = emit_status;
  assign res.bad_char = emit_bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pack_r  <= '0;
      esc_r   <= '0;
      seen_r  <= 1'b0;
    end else if (step_adv) begin
      phase_r <= phase_nxt;
      pack_r  <= pack_nxt;
      esc_r   <= esc_nxt;
      seen_r  <= seen_nxt;
    end
  end
endmodule

@@ design/cld_out_reg.sv @@
// ---------------------------------------------------------------------------
// Result register
// Holds one decoded result until the downstream side takes it.
// ---------------------------------------------------------------------------
module cld_out_reg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cld_pkg::cld_result_t        res,
  output logic                        out_free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cld_pkg::VALUE_W-1:0] out_value,
  output logic [1:0]                  out_status,
  output logic [cld_pkg::CH_W-1:0]    out_bad_char
);
  import cld_pkg::*;

  logic               valid_r;
  logic               valid_nxt;
  logic [VALUE_W-1:0] value_r;
  logic [1:0]         status_r;
  logic [CH_W-1:0]    bad_r;

  assign out_free     = !valid_r || out_ready;
  assign out_valid    = valid_r;
  assign out_value    = value_r;
  assign out_status   = status_r;
  assign out_bad_char = bad_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      value_r  <= res.value;
      status_r <= res.status;
      bad_r    <= res.bad_char;
    end
  end
endmodule

@@ design/char_literal_decoder_core.sv @@
// ---------------------------------------------------------------------------
// Character literal decoder
// Decodes a C character literal from a byte stream, one byte per transfer.
// ---------------------------------------------------------------------------
//  channel   | direction | payload
//  in_chan   | sink      | ch
//  out_chan  | source    | value, status, bad_char
//
// A byte is decoded during the cycle it sits in the input register; its
// result, if any, is shown by the result register from the following cycle.
// One byte is taken every cycle unless the decode step stalls; the decode step sets the rate.
// A waiting result stalls only a byte that itself produces a result.
// Reset is synchronous and returns the decoder to idle with both registers empty.
module char_literal_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  cld_in_if.sink     in_chan,
  cld_out_if.source  out_chan
);
  import cld_pkg::*;

  logic            hold_valid;
  logic [CH_W-1:0] hold_ch;
  logic            step_adv;
  logic            out_free;
  cld_result_t     res;

  cld_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_ch     (in_chan.ch),
    .step_adv  (step_adv),
    .hold_valid(hold_valid),
    .hold_ch   (hold_ch)
  );

  cld_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .ch_valid(hold_valid),
    .ch      (hold_ch),
    .out_free(out_free),
    .step_adv(step_adv),
    .res     (res)
  );

  cld_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .res         (res),
    .out_free    (out_free),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_value   (out_chan.value),
    .out_status  (out_chan.status),
    .out_bad_char(out_chan.bad_char)
  );
endmodule

@@ design/cld_checker.sv @@
// ---------------------------------------------------------------------------
// Character literal decoder checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "char_literal_decoder_core_assert.svh"

module cld_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cld_pkg::VALUE_W-1:0] out_value,
  input logic [1:0]                  out_status,
  input logic [cld_pkg::CH_W-1:0]    out_bad_char
);
  import cld_pkg::*;

  `CLD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_status) && $stable(out_bad_char))
  `CLD_ASSERT_NOW(a_err_no_value, out_valid && out_status != ST_OK, out_value == '0)
  `CLD_ASSERT_NOW(a_bad_only_err, out_valid && (out_status == ST_OK || out_status == ST_UNTERM), out_bad_char == '0)
  `CLD_ASSERT_NOW(a_quote_exp_char, out_valid && out_status == ST_QUOTE, out_bad_char != CH_QUOTE && out_bad_char != CH_SPACE)
  `CLD_ASSERT_NOW(a_unexp_is_quote, out_valid && out_status == ST_UNEXP, out_bad_char == CH_QUOTE)
endmodule

bind char_literal_decoder_core cld_checker u_cld_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_value   (out_chan.value),
  .out_status  (out_chan.status),
  .out_bad_char(out_chan.bad_char)
);

@@ dv/tb_char_literal_decoder_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the character literal decoder
// A short directed text covers the corner cases of the literal grammar.
// Random literals follow: plain bytes, simple, hex and octal escapes, long
// literals and broken endings. A byte-level decoder in the testbench
// predicts every result, and the results are checked in order while both
// channels idle at random.
// ---------------------------------------------------------------------------
module tb_char_literal_decoder_core;
  import cld_pkg::*;

  localparam int                NUM_BYTES     = 1500;
  localparam int                LONG_HOLD_AT  = 300;
  localparam int                LONG_HOLD     = 300;
  localparam int                DRAIN_AT      = 700;
  localparam int                CALM_FROM     = 1000;
  localparam int                CALM_TO       = 1200;
  localparam int                DRAIN_CYCLES  = 10;
  localparam int                CYCLE_LIMIT   = 1000000;
  localparam logic [PACK_W-1:0] PACK_LIMIT    = 64'h007F_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    LIT_IDLE,
    LIT_OPEN,
    LIT_MORE,
    LIT_ESC,
    LIT_HEX,
    LIT_OCT
  } lit_phase_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    cld_status_e_t      status;
    logic [CH_W-1:0]    bad_char;
  } lit_result_t;

  logic clk;
  logic rst_n = 1'b0;

  cld_in_if  in_chan ();
  cld_out_if out_chan ();

  char_literal_decoder_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic [CH_W-1:0]   text_q[$];
  lit_result_t       lit_exp_q[$];

  lit_phase_t        lit_phase;
  logic [PACK_W-1:0] lit_pack;
  logic [CH_W-1:0]   esc_acc;
  logic              esc_any;

  int bytes_sent;
  int results_seen;
  int err_count;
  int cycle_count;
  int status_seen[4];
  int send_gap;
  int hold_left;
  bit drain_done;
  bit long_hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Decoder state for the expected results.
  function automatic void lit_emit(logic [PACK_W-1:0] v, cld_status_e_t st,
                                   logic [CH_W-1:0] bad);
    lit_result_t r;
    r.value    = v[VALUE_W-1:0];
    r.status   = st;
    r.bad_char = bad;
    lit_exp_q.push_back(r);
    lit_phase = LIT_IDLE;
  endfunction

  function automatic void lit_push(logic [CH_W-1:0] b);
    lit_pack = {lit_pack[PACK_W-CH_W-1:0], b};
  endfunction

  function automatic void lit_start(logic [CH_W-1:0] c);
    if (c == CH_BSLASH) begin
      lit_phase = LIT_ESC;
    end else begin
      lit_push(c);
      lit_phase = LIT_MORE;
    end
  endfunction

  function automatic void lit_after(logic [CH_W-1:0] c);
    if (c == CH_QUOTE) begin
      lit_emit(lit_pack, ST_OK, '0);
    end else if (c == CH_NUL || c == CH_NL || lit_pack > PACK_LIMIT) begin
      lit_emit('0, ST_UNTERM, '0);
    end else begin
      lit_start(c);
    end
  endfunction

  function automatic void lit_decode(logic [CH_W-1:0] c);
    logic [CH_W-1:0] m;
    logic [CH_W-1:0] dig;
    logic            simple;
    logic            is_dig;
    m      = '0;
    dig    = '0;
    simple = 1'b1;
    is_dig = 1'b1;
    case (lit_phase)
      LIT_OPEN: begin
        if (c == CH_NUL) lit_emit('0, ST_UNTERM, '0);
        else lit_start(c);
      end
      LIT_MORE: begin
        lit_after(c);
      end
      LIT_ESC: begin
        case (c)
          "a":                         m = 8'h07;
          "b":                         m = 8'h08;
          "f":                         m = 8'h0C;
          "n":                         m = 8'h0A;
          "r":                         m = 8'h0D;
          "t":                         m = 8'h09;
          "v":                         m = 8'h0B;
          CH_QUOTE, 8'h22, CH_BSLASH:  m = c;
          default:                     simple = 1'b0;
        endcase
        if (simple) begin
          lit_push(m);
          lit_phase = LIT_MORE;
        end else if (c == CH_X) begin
          lit_phase = LIT_HEX;
          esc_acc   = '0;
          esc_any   = 1'b0;
        end else if (c >= "0" && c <= "7") begin
          lit_phase = LIT_OCT;
          dig       = c - "0";
          esc_acc   = dig;
          esc_any   = 1'b1;
        end else begin
          lit_emit('0, ST_UNTERM, '0);
        end
      end
      LIT_HEX: begin
        if (c >= "0" && c <= "9") dig = c - "0";
        else if (c >= "a" && c <= "f") dig = c - "a" + 8'd10;
        else if (c >= "A" && c <= "F") dig = c - "A" + 8'd10;
        else is_dig = 1'b0;
        if (is_dig) begin
          esc_acc = {esc_acc[3:0], dig[3:0]};
          esc_any = 1'b1;
        end else if (!esc_any) begin
          if (c == CH_QUOTE) lit_emit('0, ST_UNEXP, c);
          else lit_emit('0, ST_UNTERM, '0);
        end else begin
          lit_push(esc_acc);
          lit_after(c);
        end
      end
      LIT_OCT: begin
        if (c >= "0" && c <= "7") begin
          dig     = c - "0";
          esc_acc = {esc_acc[4:0], dig[2:0]};
        end else begin
          lit_push(esc_acc);
          lit_after(c);
        end
      end
      default: begin
        if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
        end else if (c == CH_QUOTE) begin
          lit_phase = LIT_OPEN;
          lit_pack  = '0;
          esc_acc   = '0;
          esc_any   = 1'b0;
        end else begin
          lit_emit('0, ST_QUOTE, c);
        end
      end
    endcase
  endfunction

  function automatic int idle_len();
    int r;
    if (bytes_sent >= CALM_FROM && bytes_sent < CALM_TO) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Stimulus text.
  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic logic [CH_W-1:0] pick_space();
    int r;
    r = $urandom_range(0, 5);
    if (r == 5) return CH_SPACE;
    return 8'h09 + r[7:0];
  endfunction

  function automatic void add_unit(bit first);
    string           esc_letters;
    string           hex_digits;
    logic [CH_W-1:0] b;
    int              r;
    int              n;
    esc_letters = "abfnrtv'\"\\";
    hex_digits  = "0123456789abcdefABCDEF";
    r = $urandom_range(0, 99);
    if (r < 50) begin
      b = CH_W'($urandom_range(1, 255));
      if (!first && (b == CH_QUOTE || b == CH_NL || b == CH_BSLASH)) b = "A";
      text_q.push_back(b);
    end else if (r < 70) begin
      text_q.push_back(CH_BSLASH);
      text_q.push_back(esc_letters[$urandom_range(0, esc_letters.len() - 1)]);
    end else if (r < 85) begin
      text_q.push_back(CH_BSLASH);
      text_q.push_back(CH_X);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        text_q.push_back(hex_digits[$urandom_range(0, hex_digits.len() - 1)]);
    end else begin
      text_q.push_back(CH_BSLASH);
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) text_q.push_back(CH_W'("0" + $urandom_range(0, 7)));
    end
  endfunction

  function automatic void add_literal();
    int n;
    int r;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) text_q.push_back(pick_space());
    if ($urandom_range(0, 9) == 0) text_q.push_back(CH_W'($urandom_range(0, 255)));
    text_q.push_back(CH_QUOTE);
    r = $urandom_range(0, 99);
    if (r < 70) n = $urandom_range(1, 4);
    else if (r < 90) n = $urandom_range(5, 8);
    else n = 9;
    for (int i = 0; i < n; i++) add_unit(i == 0);
    r = $urandom_range(0, 99);
    if (r < 80) begin
      text_q.push_back(CH_QUOTE);
    end else if (r < 85) begin
      text_q.push_back(CH_NL);
    end else if (r < 88) begin
      text_q.push_back(CH_NUL);
    end else if (r < 92) begin
      text_q.push_back(CH_BSLASH);
      text_q.push_back(CH_W'($urandom_range(0, 255)));
    end else if (r < 96) begin
      text_q.push_back(CH_BSLASH);
      text_q.push_back(CH_X);
      text_q.push_back(($urandom_range(0, 1) == 0) ? CH_QUOTE : "g");
    end else begin
      text_q.push_back(CH_W'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    push_text(" \t'A'");
    push_text("Z");
    text_q.push_back(CH_NUL);
    push_text("'''");
    push_text("'\\x'");
    push_text("'\\q");
    text_q.push_back(CH_QUOTE);
    text_q.push_back(CH_NUL);
    push_text("'\\377'");
    while (text_q.size() < NUM_BYTES) add_literal();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (text_q.size() != 0 || in_chan.valid) @(posedge clk);
    while (lit_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d input bytes and %0d results in %0d cycles.",
             bytes_sent, results_seen, cycle_count);
    $display("Results: %0d ok, %0d quote expected, %0d unterminated, %0d unexpected.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (err_count == 0 && lit_exp_q.size() == 0) begin
      $display("tb_char_literal_decoder_core passed");
    end else begin
      $display("tb_char_literal_decoder_core failed");
    end
    $finish;
  end

  // Sender: each accepted byte also advances the expected decoder state.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.ch    <= '0;
      send_gap   = 0;
      lit_phase  = LIT_IDLE;
      lit_pack   = '0;
      esc_acc    = '0;
      esc_any    = 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        lit_decode(in_chan.ch);
        bytes_sent++;
      end
      if (in_chan.valid && !in_chan.ready) begin
      end else if (send_gap > 0) begin
        in_chan.valid <= 1'b0;
        send_gap--;
      end else if (!drain_done && bytes_sent >= DRAIN_AT) begin
        in_chan.valid <= 1'b0;
        if (lit_exp_q.size() == 0) drain_done = 1'b1;
      end else if (text_q.size() > 0) begin
        in_chan.valid <= 1'b1;
        in_chan.ch    <= text_q.pop_front();
        send_gap = idle_len();
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Receiver stalls, with one long hold-off that backs up the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (!long_hold_done && bytes_sent >= LONG_HOLD_AT) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (hold_left == 0 && $urandom_range(0, 5) == 0) begin
        hold_left = idle_len();
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    lit_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      status_seen[out_chan.status]++;
      if (lit_exp_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("ERROR: result with nothing expected: value %h status %0d bad_char %h",
                   out_chan.value, out_chan.status, out_chan.bad_char);
      end else begin
        want = lit_exp_q.pop_front();
        if (out_chan.value !== want.value || out_chan.status !== want.status ||
            out_chan.bad_char !== want.bad_char) begin
          err_count++;
          if (err_count <= 10)
            $display("ERROR: result %0d expected value %h status %0d bad_char %h, got %h %0d %h",
                     results_seen, want.value, want.status, want.bad_char,
                     out_chan.value, out_chan.status, out_chan.bad_char);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d bytes left and %0d results pending.",
               cycle_count, text_q.size(), lit_exp_q.size());
      $display("tb_char_literal_decoder_core failed");
      $finish;
    end
  end

endmodule

@@ char_literal_decoder_core.f @@
+incdir+design
design/cld_pkg.sv
design/cld_if.sv
design/cld_in_reg.sv
design/cld_step.sv
design/cld_out_reg.sv
design/char_literal_decoder_core.sv
design/cld_checker.sv
dv/tb_char_literal_decoder_core.sv
